[src/sktt_pkg.sv]
`timescale 1ns / 1ps
// sktt_pkg: shared types and codes for the sorted key/token table
// no dependencies
package sktt_pkg;

  localparam int KEY_W = 64;
  localparam int TOK_W = 16;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 7;
  localparam int CAP_W = 7;
  localparam int CAP_RESET = 64;
  localparam logic [2:0] CFG_IDX_CAP = 3'd0;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SORT   = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_OOB      = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_UNSORTED = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SORT,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_CLEAR,
    CC_WRITE,
    CC_SHIFT,
    CC_SORT
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TOK_W-1:0]  tok;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [TOK_W-1:0]  tok;
  } chain_t;

  typedef struct packed {
    cell_op_t          op;
    logic              phase;
    logic [KEY_W-1:0]  key;
    logic [TOK_W-1:0]  tok;
  } cell_cmd_t;

endpackage

[src/sktt_if.sv]
`timescale 1ns / 1ps
// sktt_in_if / sktt_out_if: valid/ready channels of the table
// depends on sktt_pkg
interface sktt_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  opcode;
  logic [sktt_pkg::KEY_W-1:0]  key;
  logic [sktt_pkg::TOK_W-1:0]  token_value;
  logic [5:0]                  entry_index;
  modport source (output valid, opcode, key, token_value, entry_index, input ready);
  modport sink (input valid, opcode, key, token_value, entry_index, output ready);
endinterface

interface sktt_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      status;
  logic [sktt_pkg::OUT_IDX_W-1:0]  result_index;
  logic [sktt_pkg::TOK_W-1:0]      result_token;
  logic [sktt_pkg::OUT_CNT_W-1:0]  entry_count;
  logic                            sorted_flag;
  modport source (output valid, status, result_index, result_token, entry_count,
                  sorted_flag, input ready);
  modport sink (input valid, status, result_index, result_token, entry_count,
                sorted_flag, output ready);
endinterface

[src/sktt_cell.sv]
`timescale 1ns / 1ps
// sktt_cell: one table slot with neighbor moves and a match chain stage
// depends on sktt_pkg
module sktt_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sktt_pkg::cell_cmd_t cmd,
  input  logic                wr_en,
  input  logic                sh_en,
  input  sktt_pkg::entry_t    left,
  input  sktt_pkg::entry_t    right,
  output sktt_pkg::entry_t    ent,
  input  sktt_pkg::chain_t    chain_in,
  input  logic [IW-1:0]       chain_idx_in,
  output sktt_pkg::chain_t    chain_out,
  output logic [IW-1:0]       chain_idx_out
);

  localparam logic ODD = 1'(IDX % 2);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  sktt_pkg::entry_t ent_r, ent_nxt;
  sktt_pkg::chain_t chain_r;
  logic [IW-1:0]    chain_idx_r;
  logic             hit, take_r, take_l;

  assign hit = ent_r.valid && (ent_r.key == cmd.key);
  // odd-even transposition: pair with right when parity matches phase
  assign take_r = (ODD == cmd.phase) && ent_r.valid && right.valid &&
                  (ent_r.key > right.key);
  assign take_l = (ODD != cmd.phase) && ent_r.valid && left.valid &&
                  (left.key > ent_r.key);

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      sktt_pkg::CC_CLEAR: ent_nxt = '0;
      sktt_pkg::CC_WRITE: begin
        if (wr_en) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.key   = cmd.key;
          ent_nxt.tok   = cmd.tok;
        end
      end
      sktt_pkg::CC_SHIFT: begin
        if (sh_en) ent_nxt = right;
      end
      sktt_pkg::CC_SORT: begin
        if (take_r) ent_nxt = right;
        else if (take_l) ent_nxt = left;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.key <= ent_nxt.key;
    ent_r.tok <= ent_nxt.tok;
    // first hit from the left wins and rides down the row
    if (chain_in.hit) begin
      chain_r     <= chain_in;
      chain_idx_r <= chain_idx_in;
    end else begin
      chain_r.hit <= hit;
      chain_r.tok <= ent_r.tok;
      chain_idx_r <= MY_IDX;
    end
  end

  assign ent           = ent_r;
  assign chain_out     = chain_r;
  assign chain_idx_out = chain_idx_r;

endmodule

[src/sorted_key_token_table_top.sv]
`timescale 1ns / 1ps
// sorted_key_token_table_top: key/token table built as a row of slot cells
// depends on sktt_pkg, sktt_if (sktt_in_if, sktt_out_if) and sktt_cell
//
// usage
//  - in_bus carries one command beat: opcode, key, token_value, entry_index
//  - out_bus returns exactly one result beat per command: status, result_index,
//    result_token, entry_count, sorted_flag
//  - cfg_* is an APB-style port; capacity_in_use sits at byte address 0
//  - keys are cut at the first zero byte and after KEY_CHARS bytes on entry
//  - clear, remove and unused opcodes: straight from idle to the finishing step
//  - add and search: the match chain runs through the row of DEPTH cells,
//    one cell per cycle, before the finishing step
//  - sort: one odd-even compare/swap phase per cycle before the finishing step
//  - in_bus.ready is high only when idle, so a new beat is taken only after
//    the finishing step of the last command
//  - one command is in work at a time; a new beat is taken while the last
//    result still waits in the output register
//  - when the receiver stalls, the block finishes its work and holds the
//    result-producing step until the output register is free
//  - reset empties the table, clears the sorted flag and sets capacity to 64
module sorted_key_token_table_top #(
  parameter int DEPTH     = 64,
  parameter int KEY_CHARS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  sktt_in_if.sink           in_bus,
  sktt_out_if.source        out_bus,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > sktt_pkg::CAP_W) ? CW : sktt_pkg::CAP_W;
  localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);
  localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);

  // configuration
  logic [sktt_pkg::CAP_W-1:0] cap_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == sktt_pkg::CFG_IDX_CAP[0]);
  assign cfg_prdata = (cfg_paddr[2] == sktt_pkg::CFG_IDX_CAP[0]) ?
                      32'(cap_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= sktt_pkg::CAP_W'(sktt_pkg::CAP_RESET);
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[sktt_pkg::CAP_W-1:0];
    end
  end

  // key normalization: stop at first zero byte or after KEY_CHARS bytes
  logic [sktt_pkg::KEY_W-1:0] key_norm;
  always_comb begin
    logic run;
    run = 1'b1;
    key_norm = '0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_CHARS || in_bus.key[56-8*i +: 8] == 8'd0) run = 1'b0;
      if (run) key_norm[56-8*i +: 8] = in_bus.key[56-8*i +: 8];
    end
  end

  // control state
  sktt_pkg::state_t st_r, st_nxt;
  logic [2:0]                 op_r;
  logic [sktt_pkg::KEY_W-1:0] key_r;
  logic [sktt_pkg::TOK_W-1:0] tok_r;
  logic [5:0]                 idx_r;
  logic [IW-1:0]              step_r;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       ord_r, ord_nxt;
  logic                       ov_r;
  logic                       out_free, in_beat, commit;

  // output register
  logic [2:0]                      o_status_r, o_status_nxt;
  logic [sktt_pkg::OUT_IDX_W-1:0]  o_idx_r, o_idx_nxt;
  logic [sktt_pkg::TOK_W-1:0]      o_tok_r, o_tok_nxt;

  assign out_free     = !ov_r || out_bus.ready;
  assign in_bus.ready = (st_r == sktt_pkg::S_IDLE);
  assign in_beat      = in_bus.valid && in_bus.ready;
  assign commit       = (st_r == sktt_pkg::S_FIN) && out_free;

  // cell row
  sktt_pkg::entry_t ents [DEPTH];
  sktt_pkg::chain_t chains [DEPTH];
  logic [IW-1:0]    chain_idx [DEPTH];
  logic [DEPTH-1:0] wr_en, sh_en, valid_vec;
  sktt_pkg::cell_cmd_t cmd;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      sktt_pkg::entry_t lft, rgt;
      sktt_pkg::chain_t cin;
      logic [IW-1:0]    cidx;
      if (g == 0) begin : g_head
        assign lft  = '0;
        assign cin  = '0;
        assign cidx = '0;
      end else begin : g_body
        assign lft  = ents[g-1];
        assign cin  = chains[g-1];
        assign cidx = chain_idx[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign rgt = '0;
      end else begin : g_mid
        assign rgt = ents[g+1];
      end
      assign wr_en[g]     = (MW'(cnt_r) == MW'(g));
      assign sh_en[g]     = (MW'(g) >= MW'(idx_r));
      assign valid_vec[g] = ents[g].valid;
      sktt_cell #(.IW(IW), .IDX(g)) u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .wr_en         (wr_en[g]),
        .sh_en         (sh_en[g]),
        .left          (lft),
        .right         (rgt),
        .ent           (ents[g]),
        .chain_in      (cin),
        .chain_idx_in  (cidx),
        .chain_out     (chains[g]),
        .chain_idx_out (chain_idx[g])
      );
    end
  endgenerate

  // decisions made at the finishing step
  logic [MW-1:0] cap_lim;
  logic          is_full, is_dup, is_oob, found;
  assign cap_lim = (MW'(cap_r) > DEPTH_M) ? DEPTH_M : MW'(cap_r);
  assign is_full = MW'(cnt_r) >= cap_lim;
  assign is_dup  = chains[DEPTH-1].hit;
  assign found   = chains[DEPTH-1].hit;
  assign is_oob  = MW'(idx_r) >= MW'(cnt_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sktt_pkg::S_IDLE: begin
        if (in_beat) begin
          if (in_bus.opcode == sktt_pkg::OP_ADD || in_bus.opcode == sktt_pkg::OP_SEARCH)
            st_nxt = sktt_pkg::S_SCAN;
          else if (in_bus.opcode == sktt_pkg::OP_SORT)
            st_nxt = sktt_pkg::S_SORT;
          else
            st_nxt = sktt_pkg::S_FIN;
        end
      end
      sktt_pkg::S_SCAN, sktt_pkg::S_SORT: begin
        if (step_r == LAST_STEP) st_nxt = sktt_pkg::S_FIN;
      end
      sktt_pkg::S_FIN: begin
        if (out_free) st_nxt = sktt_pkg::S_IDLE;
      end
      default: st_nxt = sktt_pkg::S_IDLE;
    endcase
  end

  // cell commands and results
  always_comb begin
    cmd.op    = sktt_pkg::CC_HOLD;
    cmd.phase = step_r[0];
    cmd.key   = key_r;
    cmd.tok   = tok_r;
    cnt_nxt   = cnt_r;
    ord_nxt   = ord_r;
    o_status_nxt = sktt_pkg::ST_OK;
    o_idx_nxt    = '0;
    o_tok_nxt    = '0;
    if (st_r == sktt_pkg::S_SORT) cmd.op = sktt_pkg::CC_SORT;
    if (commit) begin
      case (op_r)
        sktt_pkg::OP_CLEAR: begin
          cmd.op  = sktt_pkg::CC_CLEAR;
          cnt_nxt = '0;
          ord_nxt = 1'b0;
        end
        sktt_pkg::OP_ADD: begin
          if (is_full) begin
            o_status_nxt = sktt_pkg::ST_FULL;
          end else if (is_dup) begin
            o_status_nxt = sktt_pkg::ST_DUP;
          end else begin
            cmd.op    = sktt_pkg::CC_WRITE;
            o_idx_nxt = sktt_pkg::OUT_IDX_W'(cnt_r);
            cnt_nxt   = cnt_r + CW'(1);
            ord_nxt   = 1'b0;
          end
        end
        sktt_pkg::OP_REMOVE: begin
          if (is_oob) begin
            o_status_nxt = sktt_pkg::ST_OOB;
          end else begin
            cmd.op  = sktt_pkg::CC_SHIFT;
            cnt_nxt = cnt_r - CW'(1);
            ord_nxt = 1'b0;
          end
        end
        sktt_pkg::OP_SORT: ord_nxt = 1'b1;
        sktt_pkg::OP_SEARCH: begin
          if (cnt_r == '0) begin
            o_status_nxt = sktt_pkg::ST_EMPTY;
          end else if (!ord_r) begin
            o_status_nxt = sktt_pkg::ST_UNSORTED;
          end else if (found) begin
            o_idx_nxt = sktt_pkg::OUT_IDX_W'(chain_idx[DEPTH-1]);
            o_tok_nxt = chains[DEPTH-1].tok;
          end else begin
            o_status_nxt = sktt_pkg::ST_NOTFOUND;
          end
        end
        default: o_status_nxt = sktt_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= sktt_pkg::S_IDLE;
      step_r <= '0;
      cnt_r  <= '0;
      ord_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ord_r <= ord_nxt;
      if (st_r == sktt_pkg::S_SCAN || st_r == sktt_pkg::S_SORT) step_r <= step_r + IW'(1);
      else step_r <= '0;
      if (commit) ov_r <= 1'b1;
      else if (out_bus.ready) ov_r <= 1'b0;
    end
    if (in_beat) begin
      op_r  <= in_bus.opcode;
      key_r <= key_norm;
      tok_r <= in_bus.token_value;
      idx_r <= in_bus.entry_index;
    end
    if (commit) begin
      o_status_r <= o_status_nxt;
      o_idx_r    <= o_idx_nxt;
      o_tok_r    <= o_tok_nxt;
    end
  end

  assign out_bus.valid        = ov_r;
  assign out_bus.status       = o_status_r;
  assign out_bus.result_index = o_idx_r;
  assign out_bus.result_token = o_tok_r;
  assign out_bus.entry_count  = sktt_pkg::OUT_CNT_W'(cnt_r);
  assign out_bus.sorted_flag  = ord_r;

  // occupied slots always match the entry count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(cnt_r))
    else $error("slot valid bits disagree with entry count");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    MW'(cnt_r) <= DEPTH_M)
    else $error("entry count above depth");

  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (st_r == sktt_pkg::S_IDLE) && ov_r)
    else $error("finishing step did not post a result");

  a_sort_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == sktt_pkg::S_SORT) |=> $stable(cnt_r))
    else $error("entry count moved during sort");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for sorted_key_token_table_top
// drives command beats through sktt_in_if, predicts each result beat, checks out_bus
// depends on sktt_pkg, sktt_if and the block under test
module tb_top;

  localparam int TBL_DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  // one predicted result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  result_index;
    logic [15:0] result_token;
    logic [6:0]  entry_count;
    logic        sorted_flag;
  } table_result_t;

  // one command beat
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] key;
    logic [15:0] token_value;
    logic [5:0]  entry_index;
  } table_cmd_t;

  // one row of the directed part; typed_exp marks rows with a hand-read result
  typedef struct packed {
    table_cmd_t    cmd;
    logic          typed_exp;
    table_result_t exp;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sktt_in_if  in_ch ();
  sktt_out_if out_ch ();

  sorted_key_token_table_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_ch.sink),
    .out_bus     (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the table
  logic [63:0] shadow_keys [TBL_DEPTH];
  logic [15:0] shadow_tokens [TBL_DEPTH];
  int unsigned shadow_count;
  bit          shadow_ordered;
  int unsigned shadow_capacity;

  table_result_t pending_results[$];
  int  mismatch_count = 0;
  int  checked_count = 0;
  int  idle_cycles;
  int  sink_stall_mode;   // 0 none, 1 light, 2 heavy

  // key is cut at its first zero byte
  function automatic logic [63:0] trim_key(logic [63:0] k);
    logic [63:0] r;
    bit          stop;
    r = '0;
    stop = 0;
    for (int i = 0; i < 8; i++) begin
      if (k[56-8*i +: 8] == 8'h00) stop = 1;
      if (!stop) r[56-8*i +: 8] = k[56-8*i +: 8];
    end
    return r;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < TBL_DEPTH; i++) begin
      shadow_keys[i] = '0;
      shadow_tokens[i] = '0;
    end
    shadow_count = 0;
    shadow_ordered = 0;
  endfunction

  // applies one command to the shadow table and returns the result beat
  function automatic table_result_t apply_table_cmd(table_cmd_t c);
    table_result_t r;
    logic [63:0]   k;
    int unsigned   cap, lo, hi, mid, j;
    logic [63:0]   mk;
    logic [15:0]   mt;
    r = '0;
    r.status = sktt_pkg::ST_OK;
    k = trim_key(c.key);
    case (c.opcode)
      sktt_pkg::OP_CLEAR: wipe_table();
      sktt_pkg::OP_ADD: begin
        cap = (shadow_capacity > TBL_DEPTH) ? TBL_DEPTH : shadow_capacity;
        if (shadow_count >= cap) r.status = sktt_pkg::ST_FULL;
        else begin
          for (int i = 0; i < shadow_count; i++)
            if (shadow_keys[i] == k) r.status = sktt_pkg::ST_DUP;
          if (r.status == sktt_pkg::ST_OK) begin
            shadow_keys[shadow_count] = k;
            shadow_tokens[shadow_count] = c.token_value;
            r.result_index = 6'(shadow_count);
            shadow_count++;
            shadow_ordered = 0;
          end
        end
      end
      sktt_pkg::OP_REMOVE: begin
        if (c.entry_index >= shadow_count) r.status = sktt_pkg::ST_OOB;
        else begin
          for (int i = c.entry_index; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_tokens[i] = shadow_tokens[i+1];
          end
          shadow_count--;
          shadow_keys[shadow_count] = '0;
          shadow_tokens[shadow_count] = '0;
          shadow_ordered = 0;
        end
      end
      sktt_pkg::OP_SORT: begin
        // stable insertion sort, equal keys keep their order
        for (int i = 1; i < shadow_count; i++) begin
          mk = shadow_keys[i];
          mt = shadow_tokens[i];
          j = i;
          while (j > 0 && shadow_keys[j-1] > mk) begin
            shadow_keys[j] = shadow_keys[j-1];
            shadow_tokens[j] = shadow_tokens[j-1];
            j--;
          end
          shadow_keys[j] = mk;
          shadow_tokens[j] = mt;
        end
        shadow_ordered = 1;
      end
      sktt_pkg::OP_SEARCH: begin
        if (shadow_count == 0) r.status = sktt_pkg::ST_EMPTY;
        else if (!shadow_ordered) r.status = sktt_pkg::ST_UNSORTED;
        else begin
          r.status = sktt_pkg::ST_NOTFOUND;
          lo = 0;
          hi = shadow_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] == k) begin
              r.status = sktt_pkg::ST_OK;
              r.result_index = 6'(mid);
              r.result_token = shadow_tokens[mid];
              break;
            end else if (shadow_keys[mid] < k) lo = mid + 1;
            else hi = mid;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(shadow_count);
    r.sorted_flag = shadow_ordered;
    return r;
  endfunction

  // gap length: mostly short, sometimes long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // result side: random stalls, sample at rising edge
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_stall_mode == 0) out_ch.ready <= 1'b1;
      else if (gap > 0) begin
        out_ch.ready <= 1'b0;
        gap--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(99) < (sink_stall_mode == 2 ? 40 : 15)) gap = pick_gap();
      end
    end
  end

  // checker: compares each result beat with the oldest expectation
  always @(posedge clk) begin
    table_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.result_index = out_ch.result_index;
      got.result_token = out_ch.result_token;
      got.entry_count = out_ch.entry_count;
      got.sorted_flag = out_ch.sorted_flag;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: st=%0d idx=%0d tok=%h cnt=%0d srt=%0d",
                   got.status, got.result_index, got.result_token,
                   got.entry_count, got.sorted_flag);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d mismatch: exp st=%0d idx=%0d tok=%h cnt=%0d srt=%0d,",
                      " got st=%0d idx=%0d tok=%h cnt=%0d srt=%0d"},
                     checked_count, want.status, want.result_index, want.result_token,
                     want.entry_count, want.sorted_flag, got.status,
                     got.result_index, got.result_token, got.entry_count,
                     got.sorted_flag);
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // register write: setup then access beat, block is idle
  task automatic write_capacity(int unsigned value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * sktt_pkg::CFG_IDX_CAP);
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    shadow_capacity = value & 32'h7f;
  endtask

  // drops valid, then waits until every expected result has come
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // waits for the table to drain, then waits for internal work to settle
  task automatic drain_results();
    wait_all_results();
    repeat (TBL_DEPTH + 8) @(posedge clk);
  endtask

  // sends one command beat; predicts on acceptance
  task automatic send_cmd(table_cmd_t c, bit typed, table_result_t typed_exp, bit no_gap);
    table_result_t pred;
    int gap;
    gap = no_gap ? 0 : pick_gap();
    // valid drops only across a gap, so it gets one assignment per step
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= c.opcode;
    in_ch.key <= c.key;
    in_ch.token_value <= c.token_value;
    in_ch.entry_index <= c.entry_index;
    do @(posedge clk); while (!in_ch.ready);
    pred = apply_table_cmd(c);
    pending_results.push_back(typed ? typed_exp : pred);
    @(negedge clk);
  endtask

  function automatic table_cmd_t mk_cmd(logic [2:0] op, logic [63:0] k,
                                        logic [15:0] t, logic [5:0] ix);
    table_cmd_t c;
    c.opcode = op;
    c.key = k;
    c.token_value = t;
    c.entry_index = ix;
    return c;
  endfunction

  function automatic table_result_t mk_res(logic [2:0] st, logic [5:0] ix,
                                           logic [15:0] t, logic [6:0] n, logic s);
    table_result_t r;
    r.status = st;
    r.result_index = ix;
    r.result_token = t;
    r.entry_count = n;
    r.sorted_flag = s;
    return r;
  endfunction

  // random key: mostly short strings from a small alphabet so duplicates and hits occur
  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    int          len;
    int p;
    p = $urandom_range(99);
    if (p < 10) return {$urandom, $urandom};          // raw bits, may hold zero bytes
    if (p < 13) return 64'hffff_ffff_ffff_ffff;
    if (p < 15) return 64'h0;
    k = '0;
    len = $urandom_range(8, 1);
    for (int i = 0; i < len; i++) k[56-8*i +: 8] = 8'(8'h61 + $urandom_range(3));
    return k;
  endfunction

  // weighted random command
  function automatic table_cmd_t rand_cmd();
    int p;
    logic [2:0] op;
    p = $urandom_range(99);
    if (p < 40) op = sktt_pkg::OP_ADD;
    else if (p < 65) op = sktt_pkg::OP_SEARCH;
    else if (p < 77) op = sktt_pkg::OP_SORT;
    else if (p < 89) op = sktt_pkg::OP_REMOVE;
    else if (p < 93) op = sktt_pkg::OP_CLEAR;
    else op = 3'($urandom_range(7, 5));
    return mk_cmd(op, rand_key(), 16'($urandom),
                  ($urandom_range(3) == 0) ? 6'($urandom) :
                  6'($urandom_range(shadow_count > 0 ? shadow_count : 1)));
  endfunction

  directed_row_t directed_rows[$];

  initial begin
    table_result_t none;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = sktt_pkg::OP_CLEAR;
    in_ch.key = '0;
    in_ch.token_value = '0;
    in_ch.entry_index = '0;
    sink_stall_mode = 1;
    none = '0;
    wipe_table();
    shadow_capacity = sktt_pkg::CAP_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table: after reset, extremes, every status code but full, special cases
    directed_rows = '{
      '{mk_cmd(sktt_pkg::OP_SEARCH, 64'h61, 0, 0), 1,
        mk_res(sktt_pkg::ST_EMPTY, 0, 0, 0, 0)},
      '{mk_cmd(sktt_pkg::OP_REMOVE, 0, 0, 0), 1,
        mk_res(sktt_pkg::ST_OOB, 0, 0, 0, 0)},
      '{mk_cmd(sktt_pkg::OP_SORT, 0, 0, 0), 1,
        mk_res(sktt_pkg::ST_OK, 0, 0, 0, 1)},
      '{mk_cmd(sktt_pkg::OP_SEARCH, 0, 0, 0), 1,
        mk_res(sktt_pkg::ST_EMPTY, 0, 0, 0, 1)},
      '{mk_cmd(sktt_pkg::OP_ADD, 64'hffff_ffff_ffff_ffff, 16'hffff, 6'h3f), 1,
        mk_res(sktt_pkg::ST_OK, 0, 0, 1, 0)},
      '{mk_cmd(sktt_pkg::OP_SEARCH, 64'hffff_ffff_ffff_ffff, 0, 0), 1,
        mk_res(sktt_pkg::ST_UNSORTED, 0, 0, 1, 0)},
      '{mk_cmd(sktt_pkg::OP_ADD, 64'h0, 16'h1234, 0), 1,
        mk_res(sktt_pkg::ST_OK, 1, 0, 2, 0)},
      // zero first byte: trimmed to the empty key, a duplicate
      '{mk_cmd(sktt_pkg::OP_ADD, 64'h0041_4243_4445_4647, 16'h1, 0), 1,
        mk_res(sktt_pkg::ST_DUP, 0, 0, 2, 0)},
      '{mk_cmd(sktt_pkg::OP_ADD, 64'h6200_6364_0000_0000, 16'h5555, 0), 0, none},
      '{mk_cmd(sktt_pkg::OP_ADD, 64'h6200_0000_0000_0000, 16'h0, 0), 0, none},
      '{mk_cmd(sktt_pkg::OP_SORT, 0, 0, 0), 0, none},
      '{mk_cmd(sktt_pkg::OP_SEARCH, 64'h6200_7777_0000_0000, 0, 0), 0, none},
      '{mk_cmd(sktt_pkg::OP_SEARCH, 64'h0, 0, 0), 0, none},
      '{mk_cmd(sktt_pkg::OP_SEARCH, 64'hffff_ffff_ffff_ffff, 0, 0), 0, none},
      '{mk_cmd(sktt_pkg::OP_SEARCH, 64'h7a00_0000_0000_0000, 0, 0), 0, none},
      '{mk_cmd(3'd5, 64'hffff_ffff_ffff_ffff, 16'hffff, 6'h3f), 0, none},
      '{mk_cmd(3'd7, 0, 0, 0), 0, none},
      '{mk_cmd(sktt_pkg::OP_REMOVE, 0, 0, 6'h3f), 0, none},
      '{mk_cmd(sktt_pkg::OP_REMOVE, 0, 0, 6'd1), 0, none},
      '{mk_cmd(sktt_pkg::OP_REMOVE, 0, 0, 6'd0), 0, none},
      '{mk_cmd(sktt_pkg::OP_CLEAR, 0, 0, 0), 1,
        mk_res(sktt_pkg::ST_OK, 0, 0, 0, 0)}
    };
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed_exp,
               directed_rows[i].exp, 0);
    drain_results();

    // random phases under several capacities, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned cap;
      bit          pressed;
      pressed = 0;
      case (ph)
        0: cap = 1;
        1: cap = 64;
        2: cap = 0;
        3: cap = 127;
        4: cap = $urandom_range(12, 2);
        default: cap = $urandom_range(64, 30);
      endcase
      write_capacity(cap);
      sink_stall_mode = ph % 3;
      for (int n = 0; n < 190; n++) begin
        // pressure: sender holds off until every result has arrived
        if (!pressed && n >= 95) begin
          wait_all_results();
          pressed = 1;
        end
        // fill-sort-search bursts to reach deep into the table
        if ($urandom_range(19) == 0) begin
          int burst;
          burst = $urandom_range(40, 5);
          for (int b = 0; b < burst; b++)
            send_cmd(mk_cmd(sktt_pkg::OP_ADD, rand_key(), 16'($urandom), 0), 0, none,
                     $urandom_range(2) == 0);
          send_cmd(mk_cmd(sktt_pkg::OP_SORT, 0, 0, 0), 0, none, 0);
          n += burst + 1;
        end else
          send_cmd(rand_cmd(), 0, none, (ph == 1) && (n < 40));
      end
      drain_results();
    end
    write_capacity(sktt_pkg::CAP_RESET);

    drain_results();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

[filelist.f]
src/sktt_pkg.sv
src/sktt_if.sv
src/sktt_cell.sv
src/sorted_key_token_table_top.sv
bench/tb_top.sv
